### hdl/fvt_pkg.sv
package fvt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int PLANE_COUNT = 6;

  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int CFG_W     = 64;

  // Corner coordinates are exact sums of two coordinates.
  localparam int EXT_W  = COORD_WIDTH + 1;
  localparam int PROD_W = EXT_W + COEF_W;
  // Plane offset plus sphere radius, before scaling by 2^14.
  localparam int OFF_W  = ((COORD_WIDTH > COEF_W) ? COORD_WIDTH : COEF_W) + 1;
  localparam int SUM_W  = ((PROD_W > OFF_W + FRAC_BITS) ? PROD_W : OFF_W + FRAC_BITS) + 2;

  localparam int IDX_W  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int ADDR_W = IDX_W + 3;

  localparam logic [2:0] FUNC_POINT  = 3'd0;
  localparam logic [2:0] FUNC_SPHERE = 3'd1;
  localparam logic [2:0] FUNC_CUBE   = 3'd2;
  localparam logic [2:0] FUNC_CBOX   = 3'd3;
  localparam logic [2:0] FUNC_MMBOX  = 3'd4;

  typedef struct packed {
    logic [2:0][EXT_W-1:0]   lo;
    logic [2:0][EXT_W-1:0]   hi;
    logic [COORD_WIDTH-1:0]  rad;
    logic                    skip;
    logic                    vis;
  } item_t;

  typedef logic [PLANE_COUNT-1:0][CFG_W-1:0] plane_set_t;

endpackage

### hdl/frustum_visibility_test_core.sv
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+-------------------------------
// input     | in_func, in_pos_*, in_ext_*            | start high, busy low
// result    | out_visible                            | out_valid, one cycle, no stall
// config    | psel, penable, pwrite, paddr, pwdata,  | APB write, pready always high
//           | prdata, pready                         |
//
// A transaction is taken every cycle; busy is never raised.
// The pipeline has one setup stage,
// then two stages per plane cell (products, then sum and compare).
// Reset clears the plane registers and the valid bits of every stage.
// The receiver cannot stall, so nothing back-pressures the cell chain.
module frustum_visibility_test_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [2:0]                             in_func,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] in_ext_x,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] in_ext_y,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] in_ext_z,
  output logic                                   out_valid,
  output logic                                   out_visible,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [fvt_pkg::ADDR_W-1:0]             paddr,
  input  logic [fvt_pkg::CFG_W-1:0]              pwdata,
  output logic [fvt_pkg::CFG_W-1:0]              prdata,
  output logic                                   pready
);

  fvt_pkg::plane_set_t planes;
  fvt_pkg::item_t      link_item  [fvt_pkg::PLANE_COUNT + 1];
  logic                link_valid [fvt_pkg::PLANE_COUNT + 1];

  assign busy = 1'b0;

  fvt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .planes  (planes)
  );

  fvt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (start && !busy),
    .func      (in_func),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .pos_z     (in_pos_z),
    .ext_x     (in_ext_x),
    .ext_y     (in_ext_y),
    .ext_z     (in_ext_z),
    .out_valid (link_valid[0]),
    .out_item  (link_item[0])
  );

  for (genvar i = 0; i < fvt_pkg::PLANE_COUNT; i++) begin : g_cell
    fvt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .plane     (planes[i]),
      .in_valid  (link_valid[i]),
      .in_item   (link_item[i]),
      .out_valid (link_valid[i + 1]),
      .out_item  (link_item[i + 1])
    );
  end

  assign out_valid   = link_valid[fvt_pkg::PLANE_COUNT];
  assign out_visible = link_item[fvt_pkg::PLANE_COUNT].vis;

endmodule

### hdl/fvt_cfg_regs.sv
module fvt_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fvt_pkg::ADDR_W-1:0]   paddr,
  input  logic [fvt_pkg::CFG_W-1:0]    pwdata,
  output logic [fvt_pkg::CFG_W-1:0]    prdata,
  output logic                         pready,
  output fvt_pkg::plane_set_t          planes
);

  logic [fvt_pkg::IDX_W-1:0] idx;
  logic                      idx_ok;
  logic [fvt_pkg::CFG_W-1:0] plane_r [fvt_pkg::PLANE_COUNT];

  assign idx    = paddr[fvt_pkg::ADDR_W-1:3];
  assign idx_ok = ({1'b0, idx} < (fvt_pkg::IDX_W + 1)'(fvt_pkg::PLANE_COUNT));
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else if (psel && penable && pwrite && idx_ok) begin
      plane_r[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = plane_r[idx];
    end
  end

  always_comb begin
    for (int i = 0; i < fvt_pkg::PLANE_COUNT; i++) begin
      planes[i] = plane_r[i];
    end
  end

endmodule

### hdl/fvt_front.sv
module fvt_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [2:0]                           func,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] pos_x,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] pos_y,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] pos_z,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] ext_x,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] ext_y,
  input  logic signed [fvt_pkg::COORD_WIDTH-1:0] ext_z,
  output logic                                 out_valid,
  output fvt_pkg::item_t                       out_item
);

  logic signed [fvt_pkg::EXT_W-1:0] pos_e [3];
  logic signed [fvt_pkg::EXT_W-1:0] ext_e [3];
  logic                             valid_r;
  fvt_pkg::item_t                   item_r;
  fvt_pkg::item_t                   item_nxt;

  assign pos_e[0] = fvt_pkg::EXT_W'(pos_x);
  assign pos_e[1] = fvt_pkg::EXT_W'(pos_y);
  assign pos_e[2] = fvt_pkg::EXT_W'(pos_z);
  assign ext_e[0] = fvt_pkg::EXT_W'(ext_x);
  assign ext_e[1] = fvt_pkg::EXT_W'(ext_y);
  assign ext_e[2] = fvt_pkg::EXT_W'(ext_z);

  // Each axis becomes a [lo, hi] interval; a point is a degenerate one.
  always_comb begin
    item_nxt      = '0;
    item_nxt.vis  = 1'b1;
    for (int k = 0; k < 3; k++) begin
      item_nxt.lo[k] = pos_e[k];
      item_nxt.hi[k] = pos_e[k];
    end
    unique case (func)
      fvt_pkg::FUNC_POINT: begin
      end
      fvt_pkg::FUNC_SPHERE: begin
        item_nxt.rad = ext_x;
      end
      fvt_pkg::FUNC_CUBE: begin
        for (int k = 0; k < 3; k++) begin
          item_nxt.lo[k] = pos_e[k] - ext_e[0];
          item_nxt.hi[k] = pos_e[k] + ext_e[0];
        end
      end
      fvt_pkg::FUNC_CBOX: begin
        for (int k = 0; k < 3; k++) begin
          item_nxt.lo[k] = pos_e[k] - ext_e[k];
          item_nxt.hi[k] = pos_e[k] + ext_e[k];
        end
      end
      fvt_pkg::FUNC_MMBOX: begin
        for (int k = 0; k < 3; k++) begin
          item_nxt.hi[k] = ext_e[k];
        end
      end
      default: begin
        // Unknown test kinds are never culled.
        item_nxt.skip = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

### hdl/fvt_cell.sv
module fvt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fvt_pkg::CFG_W-1:0]   plane,
  input  logic                        in_valid,
  input  fvt_pkg::item_t              in_item,
  output logic                        out_valid,
  output fvt_pkg::item_t              out_item
);

  logic signed [fvt_pkg::COEF_W-1:0] coef [3];
  logic signed [fvt_pkg::COEF_W-1:0] d_coef;
  logic signed [fvt_pkg::EXT_W-1:0]  op [3];
  logic signed [fvt_pkg::EXT_W-1:0]  lo_s;
  logic signed [fvt_pkg::EXT_W-1:0]  hi_s;
  logic signed [fvt_pkg::PROD_W-1:0] prod_nxt [3];
  logic signed [fvt_pkg::OFF_W-1:0]  off_nxt;

  logic signed [fvt_pkg::PROD_W-1:0] prod_r [3];
  logic signed [fvt_pkg::OFF_W-1:0]  off_r;
  logic                              a_valid_r;
  fvt_pkg::item_t                    a_item_r;

  logic signed [fvt_pkg::SUM_W-1:0]  sum;
  logic                              pass;
  logic                              b_valid_r;
  fvt_pkg::item_t                    b_item_r;
  fvt_pkg::item_t                    b_item_nxt;

  assign coef[0] = plane[15:0];
  assign coef[1] = plane[31:16];
  assign coef[2] = plane[47:32];
  assign d_coef  = plane[63:48];

  // The corner nearest the positive side uses the larger coordinate for a
  // non-negative coefficient and the smaller one otherwise.
  always_comb begin
    lo_s = '0;
    hi_s = '0;
    for (int k = 0; k < 3; k++) begin
      lo_s = in_item.lo[k];
      hi_s = in_item.hi[k];
      if (coef[k][fvt_pkg::COEF_W-1] ^ (hi_s > lo_s)) begin
        op[k] = hi_s;
      end else begin
        op[k] = lo_s;
      end
      prod_nxt[k] = fvt_pkg::PROD_W'(coef[k]) * fvt_pkg::PROD_W'(op[k]);
    end
  end

  // The sphere test d + r >= -dot folds the radius into the offset.
  assign off_nxt = fvt_pkg::OFF_W'(d_coef) +
                   fvt_pkg::OFF_W'($signed(in_item.rad));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    off_r    <= off_nxt;
    a_item_r <= in_item;
    b_item_r <= b_item_nxt;
  end

  assign sum = fvt_pkg::SUM_W'(prod_r[0]) + fvt_pkg::SUM_W'(prod_r[1]) +
               fvt_pkg::SUM_W'(prod_r[2]) +
               (fvt_pkg::SUM_W'(off_r) <<< fvt_pkg::FRAC_BITS);
  assign pass = ~sum[fvt_pkg::SUM_W-1];

  always_comb begin
    b_item_nxt     = a_item_r;
    b_item_nxt.vis = a_item_r.vis & (a_item_r.skip | pass);
  end

  assign out_valid = b_valid_r;
  assign out_item  = b_item_r;

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |=> b_valid_r)
    else $error("cell dropped a transaction between its two stages");

  a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !a_item_r.vis) |=> !b_item_r.vis)
    else $error("culled transaction became visible again");

  a_skip_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_item_r.skip) |=> (b_item_r.vis == $past(a_item_r.vis)))
    else $error("unknown test kind was culled by a plane");

endmodule
